FILE: hw/rtl/nas_pkg.sv
// Shared types and codes for the NFA active-set stepper.
// No dependencies; imported by the state cell, the top level and the testbench.
package nas_pkg;

    localparam int CmdW   = 3;
    localparam int SymW   = 8;
    localparam int IdxW   = 6;
    localparam int MapW   = 64;
    localparam int DepthW = 5;

    typedef enum logic [CmdW-1:0] {
        CMD_STEP    = 3'd0,
        CMD_UNDO    = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_WR_CHAR = 3'd3,
        CMD_WR_SUCC = 3'd4
    } t_cmd;

    // Broadcast from the top level to every state cell once per accepted request.
    typedef struct packed {
        logic              wr_char;
        logic              wr_succ;
        logic [IdxW-1:0]   row;
        logic [SymW-1:0]   symbol;
        logic              zero;
    } t_tbl_req;

endpackage

FILE: hw/rtl/nas_state_cell.sv
// One automaton state: entry character, successor column and empty-row flag.
// Depends on nas_pkg.
module nas_state_cell #(
    parameter int LIVE     = 64,
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nas_pkg::t_tbl_req    i_req,
    input  logic                 i_wr_bit,
    input  logic [LIVE-1:0]      i_active,
    output logic                 o_next_bit,
    output logic                 o_zero_next
);
    import nas_pkg::*;

    localparam int RowW = (LIVE > 1) ? $clog2(LIVE) : 1;

    logic [SymW-1:0] r_char;
    logic [LIVE-1:0] r_col;
    logic            r_zero;
    logic            own_row;

    // The column holds bit CELL_IDX of every row, so reach is a single AND-OR.
    assign own_row     = (i_req.row == IdxW'(CELL_IDX));
    assign o_next_bit  = (r_char == i_req.symbol) && (|(i_active & r_col));
    assign o_zero_next = (i_req.wr_succ && own_row) ? i_req.zero : r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char <= '0;
            r_col  <= '0;
            r_zero <= 1'b1;
        end else begin
            if (i_req.wr_char && own_row) begin
                r_char <= i_req.symbol;
            end
            if (i_req.wr_succ) begin
                r_col[i_req.row[RowW-1:0]] <= i_wr_bit;
                if (own_row) begin
                    r_zero <= i_req.zero;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/nas_hist_cell.sv
// One slot of the undo stack, a shift chain with the newest set at slot 0.
// Uses nothing from nas_pkg; instantiated by the top level.
module nas_hist_cell #(
    parameter int LIVE = 64
) (
    input  logic            i_clk,
    input  logic            i_push,
    input  logic            i_pop,
    input  logic [LIVE-1:0] i_from_newer,
    input  logic [LIVE-1:0] i_from_older,
    output logic [LIVE-1:0] o_data
);
    logic [LIVE-1:0] r_data;

    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_from_newer;
        end else if (i_pop) begin
            r_data <= i_from_older;
        end
    end

endmodule

FILE: hw/rtl/nfa_active_set_stepper.sv
// Top level of the NFA active-set stepper: command decode, active set, undo
// chain and the two-stage result path. Depends on nas_pkg and both cell types.
//
// The block accepts one request per cycle while the output side is not stalled;
// each result passes through the candidate register and then the result register.
// Each state cell forms its next active bit from its stored successor column
// ANDed with the current active set; the next request sees that set at once.
// The lowest final state is found in the following stage with an
// isolate-lowest-bit add over the registered candidate vector.
// The state table is cleared by reset itself, so no clearing pass is needed.
module nfa_active_set_stepper #(
    parameter int NUM_STATES = 64,
    parameter int HIST_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [nas_pkg::CmdW-1:0]    i_cmd,
    input  logic [nas_pkg::SymW-1:0]    i_symbol,
    input  logic [nas_pkg::IdxW-1:0]    i_state_index,
    input  logic [nas_pkg::MapW-1:0]    i_successor_mask,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [nas_pkg::MapW-1:0]    o_active_set,
    output logic                        o_final_found,
    output logic [nas_pkg::IdxW-1:0]    o_final_state,
    output logic [nas_pkg::DepthW-1:0]  o_undo_depth
);
    import nas_pkg::*;

    localparam int LIVE = (NUM_STATES < MapW) ? NUM_STATES : MapW;
    localparam int CntW = $clog2(HIST_DEPTH + 1);

    logic              accept;
    logic              a_take;
    logic              b_take;
    t_tbl_req          req;
    t_cmd              cmd;
    logic              idx_ok;

    logic [LIVE-1:0]   r_active, n_active;
    logic [CntW-1:0]   r_count, n_count;
    logic [LIVE-1:0]   step_vec;
    logic [LIVE-1:0]   zero_next;
    logic              push, pop;
    logic [LIVE-1:0]   hist_q [HIST_DEPTH];

    logic              r_a_valid;
    logic [LIVE-1:0]   r_a_active;
    logic [LIVE-1:0]   r_a_cand;
    logic [DepthW-1:0] r_a_depth;

    logic              r_o_valid;
    logic [MapW-1:0]   r_o_active;
    logic              r_o_found;
    logic [IdxW-1:0]   r_o_state;
    logic [DepthW-1:0] r_o_depth;

    logic [LIVE-1:0]   lowest;
    logic [IdxW-1:0]   low_idx;

    // Pipeline flow: the result register frees the candidate stage, which frees the input.
    assign b_take     = !r_o_valid || i_out_ready;
    assign a_take     = !r_a_valid || b_take;
    assign o_in_ready = a_take;
    assign accept     = i_in_valid && a_take;

    assign cmd    = t_cmd'(i_cmd);
    assign idx_ok = (int'(i_state_index) < LIVE);

    always_comb begin
        req.wr_char = accept && (cmd == CMD_WR_CHAR) && idx_ok;
        req.wr_succ = accept && (cmd == CMD_WR_SUCC) && idx_ok;
        req.row     = i_state_index;
        req.symbol  = i_symbol;
        req.zero    = (i_successor_mask == '0);
    end

    genvar gj;
    generate
        for (gj = 0; gj < LIVE; gj++) begin : g_state
            nas_state_cell #(
                .LIVE     (LIVE),
                .CELL_IDX (gj)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_req       (req),
                .i_wr_bit    (i_successor_mask[gj]),
                .i_active    (r_active),
                .o_next_bit  (step_vec[gj]),
                .o_zero_next (zero_next[gj])
            );
        end

        for (gj = 0; gj < HIST_DEPTH; gj++) begin : g_hist
            logic [LIVE-1:0] from_newer;
            logic [LIVE-1:0] from_older;
            if (gj == 0) begin : g_top
                assign from_newer = r_active;
            end else begin : g_mid
                assign from_newer = hist_q[gj-1];
            end
            if (gj == HIST_DEPTH - 1) begin : g_end
                assign from_older = hist_q[gj];
            end else begin : g_inner
                assign from_older = hist_q[gj+1];
            end
            nas_hist_cell #(
                .LIVE (LIVE)
            ) u_hist (
                .i_clk        (i_clk),
                .i_push       (push),
                .i_pop        (pop),
                .i_from_newer (from_newer),
                .i_from_older (from_older),
                .o_data       (hist_q[gj])
            );
        end
    endgenerate

    always_comb begin
        n_active = r_active;
        n_count  = r_count;
        push     = 1'b0;
        pop      = 1'b0;
        if (accept) begin
            case (cmd)
                CMD_STEP: begin
                    push     = 1'b1;
                    n_active = step_vec | LIVE'(1);
                    if (r_count != CntW'(HIST_DEPTH)) begin
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_UNDO: begin
                    if (r_count != '0) begin
                        pop      = 1'b1;
                        n_active = hist_q[0];
                        n_count  = r_count - 1'b1;
                    end else begin
                        n_active = LIVE'(1);
                    end
                end
                CMD_RESTART: begin
                    n_active = LIVE'(1);
                    n_count  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= LIVE'(1);
            r_count   <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_count  <= n_count;
            if (a_take) begin
                r_a_valid <= i_in_valid;
            end
            if (b_take) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    // Candidate stage: the root never counts as a final state.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_active <= n_active;
            r_a_cand   <= n_active & zero_next & ~LIVE'(1);
            r_a_depth  <= DepthW'(n_count);
        end
    end

    always_comb begin
        lowest  = r_a_cand & (~r_a_cand + 1'b1);
        low_idx = '0;
        for (int i = 0; i < LIVE; i++) begin
            if (lowest[i]) begin
                low_idx = low_idx | IdxW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_take && r_a_valid) begin
            r_o_active <= MapW'(r_a_active);
            r_o_found  <= |r_a_cand;
            r_o_state  <= low_idx;
            r_o_depth  <= r_a_depth;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_active_set  = r_o_active;
    assign o_final_found = r_o_found;
    assign o_final_state = r_o_state;
    assign o_undo_depth  = r_o_depth;

endmodule

FILE: hw/rtl/nas_checker.sv
// Port-level checks for the NFA active-set stepper, bound to its top level.
// Depends on nothing but the top level's port names.
module nas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_active_set,
    input logic        o_final_found,
    input logic [5:0]  o_final_state,
    input logic [4:0]  o_undo_depth
);

    // A reset cycle leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // The root state is part of every reported set.
    a_root_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_active_set[0])
        else $error("root state missing from active set");

    // A reported final state is a non-root state that is active in the same result.
    a_final_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_final_found) |-> (o_final_state != 6'd0)
            && o_active_set[o_final_state])
        else $error("final state not an active non-root state");

    a_final_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_final_found) |-> (o_final_state == 6'd0))
        else $error("final state nonzero without a final");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_active_set)
            && $stable(o_undo_depth))
        else $error("stalled result changed");

endmodule

bind nfa_active_set_stepper nas_checker u_nas_checker (.*);

FILE: dv/tb_nfa_active_set_stepper.sv
// Self-checking testbench for nfa_active_set_stepper: random and directed requests
// are checked against a behavioral model of the automaton. Depends on nas_pkg and the RTL.
module tb_nfa_active_set_stepper;
    import nas_pkg::*;

    localparam int NumStates  = 64;
    localparam int HistDepth  = 16;
    localparam int RandomReqs = 1500;
    localparam int StallLimit = 3000;
    localparam int HoldCycles = 250;
    localparam int DrainWait  = 20;
    localparam logic [SymW-1:0] AlphaBase = 8'h61;

    typedef struct {
        logic [CmdW-1:0] cmd;
        logic [SymW-1:0] sym;
        logic [IdxW-1:0] idx;
        logic [MapW-1:0] mask;
    } t_request;

    typedef struct {
        logic [MapW-1:0]   set;
        logic              found;
        logic [IdxW-1:0]   fstate;
        logic [DepthW-1:0] depth;
    } t_status;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_ready;
    logic [CmdW-1:0]   req_cmd = '0;
    logic [SymW-1:0]   req_sym = '0;
    logic [IdxW-1:0]   req_idx = '0;
    logic [MapW-1:0]   req_mask = '0;
    logic              o_out_valid;
    logic              out_ready = 1'b0;
    logic [MapW-1:0]   o_active_set;
    logic              o_final_found;
    logic [IdxW-1:0]   o_final_state;
    logic [DepthW-1:0] o_undo_depth;

    // Model of the automaton, updated once per accepted request.
    logic [MapW-1:0] nfa_active;
    logic [SymW-1:0] nfa_chars [NumStates];
    logic [MapW-1:0] nfa_succ [NumStates];
    logic [MapW-1:0] nfa_hist [HistDepth];
    int              nfa_hist_count;
    int              nfa_hist_pos;

    t_request cmd_backlog [$];
    t_status  status_due [$];
    t_request cur_req = '{default: '0};
    t_status  want;
    int       n_in_acc = 0;
    int       n_bad = 0;
    int       send_gap = 0;
    int       recv_gap = 0;
    int       hold_left = 0;
    int       hold_mark = 300;
    int       idle_cycles = 0;
    bit       offer;

    nfa_active_set_stepper #(
        .NUM_STATES(NumStates),
        .HIST_DEPTH(HistDepth)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (req_cmd),
        .i_symbol        (req_sym),
        .i_state_index   (req_idx),
        .i_successor_mask(req_mask),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_active_set    (o_active_set),
        .o_final_found   (o_final_found),
        .o_final_state   (o_final_state),
        .o_undo_depth    (o_undo_depth)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_status nfa_next_status(t_request r);
        logic [MapW-1:0] reach;
        logic [MapW-1:0] match;
        t_status         s;
        int              i;
        reach = '0;
        match = '0;
        case (r.cmd)
            CMD_STEP: begin
                for (i = 0; i < NumStates; i++) begin
                    if (nfa_active[i])
                        reach |= nfa_succ[i];
                    if (nfa_chars[i] == r.sym)
                        match[i] = 1'b1;
                end
                // A full history drops its oldest entry.
                nfa_hist[nfa_hist_pos] = nfa_active;
                nfa_hist_pos = (nfa_hist_pos + 1) % HistDepth;
                if (nfa_hist_count < HistDepth)
                    nfa_hist_count++;
                nfa_active = (reach & match) | 64'd1;
            end
            CMD_UNDO: begin
                if (nfa_hist_count > 0) begin
                    nfa_hist_pos = (nfa_hist_pos + HistDepth - 1) % HistDepth;
                    nfa_active = nfa_hist[nfa_hist_pos];
                    nfa_hist_count--;
                end else begin
                    nfa_active = 64'd1;
                end
            end
            CMD_RESTART: begin
                nfa_active = 64'd1;
                nfa_hist_count = 0;
                nfa_hist_pos = 0;
            end
            CMD_WR_CHAR: nfa_chars[r.idx] = r.sym;
            CMD_WR_SUCC: nfa_succ[r.idx] = r.mask;
            default: ;
        endcase
        s.set = nfa_active;
        s.found = 1'b0;
        s.fstate = '0;
        s.depth = nfa_hist_count[DepthW-1:0];
        for (i = 1; i < NumStates; i++) begin
            if (!s.found && nfa_active[i] && nfa_succ[i] == '0) begin
                s.found = 1'b1;
                s.fstate = i[IdxW-1:0];
            end
        end
        return s;
    endfunction

    function automatic bit quiet_window(int n);
        return ((n / 150) % 5) == 2;
    endfunction

    function automatic int pick_pause(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [MapW-1:0] rand_map();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [MapW-1:0] sparse_map(int bits);
        logic [MapW-1:0] m;
        int              k;
        m = '0;
        for (k = 0; k < bits; k++)
            m[IdxW'($urandom_range(0, NumStates - 1))] = 1'b1;
        return m;
    endfunction

    task automatic queue_req(logic [CmdW-1:0] cmd, logic [SymW-1:0] sym,
                             logic [IdxW-1:0] idx, logic [MapW-1:0] mask);
        t_request r;
        r.cmd = cmd;
        r.sym = sym;
        r.idx = idx;
        r.mask = mask;
        cmd_backlog.push_back(r);
    endtask

    // Gives a state an entry character from a small alphabet and a mostly sparse fan-out,
    // so that steps on that alphabet keep the active set alive.
    task automatic wire_state(int idx);
        logic [MapW-1:0] succ;
        int              r;
        r = $urandom_range(0, 99);
        if (idx == 0)
            succ = sparse_map(8);
        else if (r < 25)
            succ = '0;
        else if (r < 29)
            succ = rand_map();
        else if (r < 31)
            succ = '1;
        else
            succ = sparse_map($urandom_range(1, 4));
        queue_req(CMD_WR_CHAR, AlphaBase + SymW'($urandom_range(0, 3)), IdxW'(idx), '0);
        queue_req(CMD_WR_SUCC, SymW'($urandom_range(0, 255)), IdxW'(idx), succ);
    endtask

    task automatic flag_mismatch(string msg);
        n_bad++;
        if (n_bad <= 10)
            $display("%s", msg);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            offer = in_valid;
            if (in_valid && o_in_ready) begin
                status_due.push_back(nfa_next_status(cur_req));
                n_in_acc <= n_in_acc + 1;
                offer = 1'b0;
                send_gap = pick_pause(quiet_window(n_in_acc));
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (cmd_backlog.size() > 0) begin
                    cur_req = cmd_backlog.pop_front();
                    offer = 1'b1;
                end
            end
            in_valid <= offer;
            req_cmd  <= cur_req.cmd;
            req_sym  <= cur_req.sym;
            req_idx  <= cur_req.idx;
            req_mask <= cur_req.mask;
        end
    end

    // Result side ready, with long hold-offs that let the block back up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end else begin
            if (hold_left == 0 && n_in_acc >= hold_mark) begin
                hold_left = HoldCycles;
                hold_mark = hold_mark + 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_gap = pick_pause(quiet_window(n_in_acc));
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (status_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: set=%h found=%b state=%0d depth=%0d",
                    o_active_set, o_final_found, o_final_state, o_undo_depth));
            end else begin
                want = status_due.pop_front();
                if (o_active_set !== want.set || o_final_found !== want.found ||
                    o_final_state !== want.fstate || o_undo_depth !== want.depth)
                    flag_mismatch($sformatf({"mismatch: exp set=%h found=%b state=%0d ",
                        "depth=%0d, got set=%h found=%b state=%0d depth=%0d"},
                        want.set, want.found, want.fstate, want.depth,
                        o_active_set, o_final_found, o_final_state, o_undo_depth));
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request or a result.
    always @(posedge i_clk) begin
        if (i_rst_n && !(in_valid && o_in_ready) && !(o_out_valid && out_ready)) begin
            idle_cycles++;
            if (idle_cycles >= StallLimit) begin
                $display("Verification failed");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    initial begin
        int r;
        int k;
        int len;
        int goal;
        nfa_active = 64'd1;
        nfa_hist_count = 0;
        nfa_hist_pos = 0;
        for (k = 0; k < NumStates; k++) begin
            nfa_chars[k] = '0;
            nfa_succ[k] = '0;
        end

        // Directed part: empty table, history underflow, widest masks and
        // characters, unused codes, and a root that loops on itself.
        queue_req(CMD_STEP, 8'h00, 6'd0, '0);
        queue_req(CMD_UNDO, 8'h00, 6'd0, '0);
        queue_req(CMD_UNDO, 8'hFF, 6'd63, '1);
        queue_req(CMD_WR_SUCC, 8'h00, 6'd0, '1);
        queue_req(CMD_WR_CHAR, 8'h41, 6'd1, '0);
        queue_req(CMD_WR_CHAR, 8'h41, 6'd2, '0);
        queue_req(CMD_WR_CHAR, 8'hFF, 6'd63, '0);
        queue_req(CMD_WR_SUCC, 8'h00, 6'd2, 64'd1 << 63);
        queue_req(CMD_STEP, 8'h41, 6'd0, '0);
        queue_req(CMD_STEP, 8'hFF, 6'd0, '0);
        queue_req(CMD_STEP, 8'h00, 6'd0, '0);
        queue_req(CMD_UNDO, 8'h00, 6'd0, '0);
        queue_req(CMD_WR_SUCC, 8'h00, 6'd63, '1);
        queue_req(CMD_STEP, 8'hFF, 6'd0, '0);
        for (k = 0; k < 3; k++)
            queue_req(CmdW'(CMD_WR_SUCC + 1 + k), SymW'($urandom_range(0, 255)),
                      IdxW'($urandom_range(0, 63)), rand_map());
        queue_req(CMD_RESTART, 8'h00, 6'd0, '0);
        queue_req(CMD_WR_SUCC, 8'h00, 6'd0, '0);
        queue_req(CMD_STEP, 8'h41, 6'd0, '0);
        queue_req(CMD_WR_CHAR, 8'hFF, 6'd0, '0);
        queue_req(CMD_WR_SUCC, 8'h00, 6'd0, 64'd1);
        queue_req(CMD_STEP, 8'hFF, 6'd0, '0);
        queue_req(CMD_RESTART, 8'h00, 6'd0, '0);

        // Random part: build a whole automaton, then mostly walks over it.
        goal = cmd_backlog.size() + RandomReqs;
        for (k = 0; k < NumStates; k++)
            wire_state(k);
        while (cmd_backlog.size() < goal) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    wire_state($urandom_range(0, NumStates - 1));
            end else if (r < 18) begin
                len = $urandom_range(1, 5);
                for (k = 0; k < len; k++)
                    queue_req(CmdW'($urandom_range(0, 7)), SymW'($urandom_range(0, 255)),
                              IdxW'($urandom_range(0, 63)), rand_map());
            end else if (r < 23) begin
                queue_req(CMD_RESTART, SymW'($urandom_range(0, 255)), 6'd0, '0);
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    queue_req(CMD_UNDO, SymW'($urandom_range(0, 255)),
                              IdxW'($urandom_range(0, 63)), '0);
            end else begin
                if ($urandom_range(0, 3) == 0)
                    queue_req(CMD_RESTART, 8'h00, 6'd0, '0);
                // Some walks run past the history depth to force the oldest
                // entries out.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24)
                                                  : $urandom_range(1, 10);
                for (k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 85)
                        queue_req(CMD_STEP, AlphaBase + SymW'($urandom_range(0, 3)),
                                  6'd0, '0);
                    else if (r < 92)
                        queue_req(CMD_UNDO, 8'h00, 6'd0, '0);
                    else
                        queue_req(CMD_STEP, SymW'($urandom_range(0, 255)), 6'd0, '0);
                end
                if ($urandom_range(0, 9) < 3) begin
                    len = $urandom_range(1, 20);
                    for (k = 0; k < len; k++)
                        queue_req(CMD_UNDO, 8'h00, 6'd0, '0);
                end
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (cmd_backlog.size() > 0 || in_valid || status_due.size() > 0);
        repeat (DrainWait) @(negedge i_clk);

        if (n_bad == 0 && status_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
